@@ design/mmbf_pkg.sv @@
package mmbf_pkg;

	// Width of the raw delta carried by one poll (8 low bits plus a nibble).
	localparam int RawBits = 12;
	// Width of a decoded delta after swap and negation (room for -(-2048)).
	localparam int DeltaW = RawBits + 1;
	// Width of a held sum and of a reported movement.
	localparam int MoveW = DeltaW + 1;

	localparam logic [7:0] MotionBit   = 8'h80;
	localparam logic [7:0] XHighMask   = 8'hF0;
	localparam logic [7:0] YHighMask   = 8'h0F;
	localparam logic [7:0] QuietSatMax = 8'hFF;

	typedef logic signed [DeltaW-1:0] delta_t;
	typedef logic signed [MoveW-1:0]  move_t;

	typedef enum logic [2:0] {
		RegSwapAxes        = 3'd0,
		RegNegateX         = 3'd1,
		RegNegateY         = 3'd2,
		RegReportWindowMs  = 3'd3,
		RegQuietPollsNeed  = 3'd4,
		RegDrainUntilMs    = 3'd5,
		RegDrainCapMs      = 3'd6
	} cfg_reg_t;

	localparam int CfgIndexW = 3;

	typedef struct packed {
		logic        swap_axes;
		logic        negate_x;
		logic        negate_y;
		logic [15:0] report_window_ms;
		logic [7:0]  quiet_polls_needed;
		logic [31:0] drain_until_ms;
		logic [31:0] drain_cap_ms;
	} cfg_t;

	// Sign-extends a raw delta from its top bit.
	function automatic delta_t decode_delta(input logic [RawBits-1:0] raw);
		return delta_t'({raw[RawBits-1], raw});
	endfunction

endpackage

@@ design/mmbf_poll_if.sv @@
interface mmbf_poll_if;
	logic        valid;
	logic        ready;
	logic [7:0]  motion_byte;
	logic [7:0]  x_low;
	logic [7:0]  y_low;
	logic [7:0]  xy_high;
	logic [31:0] now_ms;

	modport source (output valid, motion_byte, x_low, y_low, xy_high, now_ms, input ready);
	modport sink   (input valid, motion_byte, x_low, y_low, xy_high, now_ms, output ready);
endinterface

@@ design/mmbf_move_if.sv @@
interface mmbf_move_if;
	logic                  valid;
	logic                  ready;
	mmbf_pkg::move_t       move_x;
	mmbf_pkg::move_t       move_y;
	logic                  x_present;
	logic                  y_present;

	modport source (output valid, move_x, move_y, x_present, y_present, input ready);
	modport sink   (input valid, move_x, move_y, x_present, y_present, output ready);
endinterface

@@ design/mmbf_cfg_if.sv @@
interface mmbf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mmbf_pkg::CfgIndexW-1:0] index;
	logic [31:0]                    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ design/mmbf_cfg_regs.sv @@
module mmbf_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	mmbf_cfg_if.sink        cfg,
	output mmbf_pkg::cfg_t  regs
);

	mmbf_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.swap_axes          <= 1'b0;
			regs_q.negate_x           <= 1'b0;
			regs_q.negate_y           <= 1'b0;
			regs_q.report_window_ms   <= 16'd30;
			regs_q.quiet_polls_needed <= 8'd3;
			regs_q.drain_until_ms     <= 32'd0;
			regs_q.drain_cap_ms       <= 32'd0;
		end else if (cfg.valid) begin
			// An index past the last register is dropped.
			unique case (cfg.index)
				mmbf_pkg::RegSwapAxes:       regs_q.swap_axes          <= cfg.data[0];
				mmbf_pkg::RegNegateX:        regs_q.negate_x           <= cfg.data[0];
				mmbf_pkg::RegNegateY:        regs_q.negate_y           <= cfg.data[0];
				mmbf_pkg::RegReportWindowMs: regs_q.report_window_ms   <= cfg.data[15:0];
				mmbf_pkg::RegQuietPollsNeed: regs_q.quiet_polls_needed <= cfg.data[7:0];
				mmbf_pkg::RegDrainUntilMs:   regs_q.drain_until_ms     <= cfg.data;
				mmbf_pkg::RegDrainCapMs:     regs_q.drain_cap_ms       <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/mmbf_delta.sv @@
module mmbf_delta (
	input  logic [7:0]            x_low,
	input  logic [7:0]            y_low,
	input  logic [7:0]            xy_high,
	input  logic                  swap_axes,
	input  logic                  negate_x,
	input  logic                  negate_y,
	output mmbf_pkg::delta_t      dx,
	output mmbf_pkg::delta_t      dy
);

	logic [7:0]       x_hi_bits;
	logic [7:0]       y_hi_bits;
	mmbf_pkg::delta_t raw_x;
	mmbf_pkg::delta_t raw_y;
	mmbf_pkg::delta_t sw_x;
	mmbf_pkg::delta_t sw_y;

	always_comb begin
		x_hi_bits = (xy_high & mmbf_pkg::XHighMask) >> 4;
		y_hi_bits = xy_high & mmbf_pkg::YHighMask;
		raw_x = mmbf_pkg::decode_delta({x_hi_bits[3:0], x_low});
		raw_y = mmbf_pkg::decode_delta({y_hi_bits[3:0], y_low});
		sw_x  = swap_axes ? raw_y : raw_x;
		sw_y  = swap_axes ? raw_x : raw_y;
		dx    = negate_x ? -sw_x : sw_x;
		dy    = negate_y ? -sw_y : sw_y;
	end

endmodule

@@ design/mouse_motion_burst_filter_core.sv @@
// The result register loads as a poll leaves the input register, and a result transfers
// once it is offered and the sink is ready.
// Throughput: one poll per cycle; the input register holds only while its own poll reports
// and an earlier result is still waiting in the result register.
// Polls that produce no result leave the pipeline without touching the output.
// Reset (arst_n low, asynchronous) empties both registers, clears the held sums, the
// confirmed flag, the last motion time and the quiet poll count, and loads register defaults.
module mouse_motion_burst_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	mmbf_poll_if.sink   poll,
	mmbf_move_if.source move,
	mmbf_cfg_if.sink    cfg
);

	// Configuration registers. Writes are expected only while no poll is in flight.
	mmbf_pkg::cfg_t regs;

	mmbf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Input register: one poll captured per transfer.
	logic        valid_s1;
	logic [7:0]  motion_s1;
	logic [7:0]  x_low_s1;
	logic [7:0]  y_low_s1;
	logic [7:0]  xy_high_s1;
	logic [31:0] now_s1;

	// Filter state carried from poll to poll.
	mmbf_pkg::move_t held_x_q;
	mmbf_pkg::move_t held_y_q;
	logic [31:0]     last_motion_q;
	logic            confirmed_q;
	logic [7:0]      quiet_cnt_q;

	// Result register.
	logic            out_valid_q;
	mmbf_pkg::move_t out_x_q;
	mmbf_pkg::move_t out_y_q;

	// Decoded deltas of the poll in the input register.
	mmbf_pkg::delta_t dx;
	mmbf_pkg::delta_t dy;

	mmbf_delta u_delta (
		.x_low     (x_low_s1),
		.y_low     (y_low_s1),
		.xy_high   (xy_high_s1),
		.swap_axes (regs.swap_axes),
		.negate_x  (regs.negate_x),
		.negate_y  (regs.negate_y),
		.dx        (dx),
		.dy        (dy)
	);

	logic            moving;
	logic            draining;
	logic [32:0]     gap;
	logic            gap_elapsed;
	logic            zero_frame;
	mmbf_pkg::move_t base_x;
	mmbf_pkg::move_t base_y;
	logic            base_conf;
	mmbf_pkg::move_t sum_x;
	mmbf_pkg::move_t sum_y;
	logic            emit;
	logic            advance;

	always_comb begin
		moving = (motion_s1 & mmbf_pkg::MotionBit) != 8'd0;

		// Startup drain: forced before drain_until_ms or until enough quiet polls,
		// never at or after drain_cap_ms.
		draining = (now_s1 < regs.drain_cap_ms) &&
			((now_s1 < regs.drain_until_ms) || (quiet_cnt_q < regs.quiet_polls_needed));

		// The gap is a signed difference: a timestamp behind the last motion
		// shows up as a borrow and never purges.
		gap         = {1'b0, now_s1} - {1'b0, last_motion_q};
		gap_elapsed = !gap[32] && (gap[31:0] >= {16'd0, regs.report_window_ms});

		zero_frame = (dx == '0) && (dy == '0);

		// A purge wipes the held sums before this frame is added.
		base_x    = gap_elapsed ? '0 : held_x_q;
		base_y    = gap_elapsed ? '0 : held_y_q;
		base_conf = gap_elapsed ? 1'b0 : confirmed_q;
		sum_x     = base_x + mmbf_pkg::move_t'(dx);
		sum_y     = base_y + mmbf_pkg::move_t'(dy);

		// A result comes only from a confirmed burst with a non-zero sum.
		emit = !draining && moving && !zero_frame && base_conf &&
			((sum_x != '0) || (sum_y != '0));

		// The input register drains unless its result would overwrite one
		// still waiting in the result register.
		advance    = valid_s1 && (!emit || !out_valid_q || move.ready);
		poll.ready = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			motion_s1  <= poll.motion_byte;
			x_low_s1   <= poll.x_low;
			y_low_s1   <= poll.y_low;
			xy_high_s1 <= poll.xy_high;
			now_s1     <= poll.now_ms;
		end
	end

	// State update, taken once per poll as it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q      <= '0;
			held_y_q      <= '0;
			last_motion_q <= '0;
			confirmed_q   <= 1'b0;
			quiet_cnt_q   <= '0;
		end else if (advance) begin
			if (draining) begin
				if (moving) begin
					quiet_cnt_q <= '0;
				end else if (quiet_cnt_q != mmbf_pkg::QuietSatMax) begin
					quiet_cnt_q <= quiet_cnt_q + 8'd1;
				end
				held_x_q    <= '0;
				held_y_q    <= '0;
				confirmed_q <= 1'b0;
			end else if (moving) begin
				if (zero_frame) begin
					// A zero frame can only purge; it leaves the motion time alone.
					if (gap_elapsed) begin
						held_x_q    <= '0;
						held_y_q    <= '0;
						confirmed_q <= 1'b0;
					end
				end else begin
					last_motion_q <= now_s1;
					confirmed_q   <= 1'b1;
					if (base_conf) begin
						// Confirmed: the sum is reported (or is zero), so it clears.
						held_x_q <= '0;
						held_y_q <= '0;
					end else begin
						// First frame of a burst is only held.
						held_x_q <= sum_x;
						held_y_q <= sum_y;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (move.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_x_q <= sum_x;
			out_y_q <= sum_y;
		end
	end

	assign move.valid     = out_valid_q;
	assign move.move_x    = out_x_q;
	assign move.move_y    = out_y_q;
	assign move.x_present = out_x_q != '0;
	assign move.y_present = out_y_q != '0;

endmodule

@@ design/mmbf_checker.sv @@
module mmbf_checker (
	input logic clk,
	input logic arst_n,
	mmbf_poll_if.sink   poll,
	mmbf_move_if.source move
);

	// A fresh result must trace back to an earlier poll transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(move.valid) |-> $past(poll.valid && poll.ready, 2))
		else $error("result appeared without a poll two cycles before");

	// A shown result is never an all-zero movement.
	assert property (@(posedge clk) disable iff (!arst_n)
		move.valid |-> (move.x_present || move.y_present))
		else $error("result carries no movement");

	// Presence flags agree with the movement values.
	assert property (@(posedge clk) disable iff (!arst_n)
		move.valid |-> ((move.x_present == (move.move_x != '0)) &&
			(move.y_present == (move.move_y != '0))))
		else $error("presence flag disagrees with movement");

	// Sums of two decoded deltas never leave the range -4096 to 4096.
	assert property (@(posedge clk) disable iff (!arst_n)
		move.valid |-> ((move.move_x >= -14'sd4096) && (move.move_x <= 14'sd4096) &&
			(move.move_y >= -14'sd4096) && (move.move_y <= 14'sd4096)))
		else $error("movement out of range");

endmodule

bind mouse_motion_burst_filter_core mmbf_checker u_mmbf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.poll   (poll),
	.move   (move)
);
